>>> design/mld_pkg.sv
// Shared types, widths and codes for the 2x2 mip level downsampler.
`timescale 1ns / 1ps
`default_nettype none
package mld_pkg;

    // Pixel and arithmetic widths
    localparam int PIX_W      = 8;
    localparam int PAIR_W     = 9;   // sum of two bytes
    localparam int SUM_W      = 10;  // sum of four bytes
    localparam int VEC_W      = 11;  // signed 2*sum-1020
    localparam int SQ_W       = 22;  // squared length
    localparam int RAD_W      = 38;  // squared length scaled by 65536
    localparam int ROOT_W     = 19;  // 256*|v|
    localparam int NUM_W      = 30;  // signed encode numerator
    localparam int DEN_W      = 20;  // 2*root
    localparam int QUO_W      = 8;
    localparam int CMP_W      = 18;  // common width for size compares

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_W    = 14;
    localparam int HEIGHT_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    localparam int MAX_WIDTH_DEF = 8192;

    // Encoding of a zero normal vector
    localparam logic [PIX_W-1:0] NORM_ZERO_XY = 8'd128;
    localparam logic [PIX_W-1:0] NORM_ZERO_Z  = 8'd255;
    localparam logic [QUO_W-1:0] QUO_SAT      = 8'd255;

    typedef enum logic [1:0] {
        JOB_RAW,
        JOB_AVG,
        JOB_NORM
    } job_kind_t;

    // One 2x2 block handed from the front end to the result stage
    typedef struct packed {
        job_kind_t                 kind;
        logic [3:0][SUM_W-1:0]     sum;
        logic                      last;
    } job_t;

    typedef enum logic {
        F_IDLE,
        F_SEND
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQ,
        B_SQRT,
        B_DIVGO,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage
`default_nettype wire

>>> design/mld_line_mem.sv
// Line store of pair sums: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mld_line_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 36
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data_reg
);

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> design/mld_isqrt.sv
// Iterative integer square root, two radicand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mld_isqrt (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [mld_pkg::RAD_W-1:0]  radicand,
    output logic                            done,
    output logic      [mld_pkg::ROOT_W-1:0] root
);
    import mld_pkg::*;

    localparam int STEPS = RAD_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int REM_W = ROOT_W + 3;

    logic [RAD_W-1:0]  x_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    // One digit step
    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], x_reg[RAD_W-1 -: 2]};
        trial  = REM_W'({root_reg, 2'b01});
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            x_reg    <= {x_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

>>> design/mld_axis_div.sv
// Restoring divider for one normal axis: 8 quotient bits, clamped to 0..255.
`timescale 1ns / 1ps
`default_nettype none
module mld_axis_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic signed [mld_pkg::NUM_W-1:0] num,
    input  wire logic        [mld_pkg::DEN_W-1:0] den,
    output logic                                  done,
    output logic             [mld_pkg::QUO_W-1:0] quo
);
    import mld_pkg::*;

    localparam int REM_W = DEN_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [REM_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [QUO_W-1:0] q_reg;
    logic             sat_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    logic [CNT_W-1:0]       bit_idx;
    logic [REM_W-1:0]       dsh;
    logic                   take;
    logic signed [NUM_W-1:0] limit;

    always_comb
    begin
        bit_idx = cnt_reg - 1'b1;
        dsh     = REM_W'(den_reg) << bit_idx;
        take    = (rem_reg >= dsh);
        limit   = $signed({2'b00, den, {QUO_W{1'b0}}});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CNT_W'(QUO_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Nonpositive numerator gives zero, quotient of 256 or more saturates
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            q_reg   <= '0;
            sat_reg <= (num >= limit);
            if (num <= 0 || num >= limit)
            begin
                rem_reg <= '0;
            end
            else
            begin
                rem_reg <= num[REM_W-1:0];
            end
        end
        else if (cnt_reg != '0)
        begin
            if (take)
            begin
                rem_reg <= rem_reg - dsh;
                q_reg   <= q_reg | (QUO_W'(1) << bit_idx);
            end
        end
    end

    assign done = done_reg;
    assign quo  = sat_reg ? QUO_SAT : q_reg;

endmodule
`default_nettype wire

>>> design/mld_back.sv
// Result stage: raw passthrough, rounded average, or normal renormalization, into the output register.
`timescale 1ns / 1ps
`default_nettype none
module mld_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      job_valid,
    output logic                           job_ready,
    input  wire mld_pkg::job_t             job,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic      [mld_pkg::PIX_W-1:0] out_red,
    output logic      [mld_pkg::PIX_W-1:0] out_green,
    output logic      [mld_pkg::PIX_W-1:0] out_blue,
    output logic      [mld_pkg::PIX_W-1:0] out_alpha,
    output logic                           level_last
);
    import mld_pkg::*;

    back_state_t state_reg, state_next;

    logic signed [VEC_W-1:0] v_reg [3];
    logic [ROOT_W-1:0]       root_reg;
    logic [PIX_W-1:0]        rgb_reg [3];
    logic [PIX_W-1:0]        alpha_reg;
    logic                    last_reg;

    logic                    accept;
    logic [SQ_W-1:0]         sq;
    logic signed [2*VEC_W-1:0] prod [3];
    logic                    sqrt_start;
    logic                    sqrt_done;
    logic [ROOT_W-1:0]       sqrt_root;
    logic                    div_start;
    logic [2:0]              div_done;
    logic [QUO_W-1:0]        quo [3];
    logic signed [NUM_W-1:0] num [3];
    logic [DEN_W-1:0]        den;

    // Rounded average of four bytes; a four-byte sum plus two stays below 1024
    function automatic logic [PIX_W-1:0] avg4(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        t = s + SUM_W'(2);
        return t[SUM_W-1:2];
    endfunction

    // Squared length of the decoded vector
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            prod[c] = v_reg[c] * v_reg[c];
        end
        sq = SQ_W'(prod[0]) + SQ_W'(prod[1]) + SQ_W'(prod[2]);
    end

    // Encode numerators: 255*(256*v + L) + L
    always_comb
    begin
        logic signed [NUM_W-1:0] t;
        logic signed [NUM_W-1:0] l_ext;
        den   = {1'b0, root_reg} << 1;
        l_ext = $signed(NUM_W'(root_reg));
        for (int c = 0; c < 3; c++)
        begin
            t      = ($signed(NUM_W'(v_reg[c])) <<< 8) + l_ext;
            num[c] = (t <<< 8) - t + l_ext;
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_ready  = 1'b0;
        out_valid  = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    state_next = (job.kind == JOB_NORM) ? B_SQ : B_OUT;
                end
            end
            B_SQ:
            begin
                if (sq == '0)
                begin
                    state_next = B_OUT;
                end
                else
                begin
                    sqrt_start = 1'b1;
                    state_next = B_SQRT;
                end
            end
            B_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = B_DIVGO;
                end
            end
            B_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (&div_done)
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign accept = job_valid && job_ready;

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            last_reg  <= job.last;
            alpha_reg <= (job.kind == JOB_RAW) ? job.sum[3][PIX_W-1:0] : avg4(job.sum[3]);
            for (int c = 0; c < 3; c++)
            begin
                v_reg[c]   <= $signed({job.sum[c], 1'b0}) - $signed(VEC_W'(1020));
                rgb_reg[c] <= (job.kind == JOB_RAW) ? job.sum[c][PIX_W-1:0]
                                                    : avg4(job.sum[c]);
            end
        end
        else if (state_reg == B_SQ && sq == '0)
        begin
            rgb_reg[0] <= NORM_ZERO_XY;
            rgb_reg[1] <= NORM_ZERO_XY;
            rgb_reg[2] <= NORM_ZERO_Z;
        end
        else if (state_reg == B_SQRT && sqrt_done)
        begin
            root_reg <= sqrt_root;
        end
        else if (state_reg == B_DIV && (&div_done))
        begin
            for (int c = 0; c < 3; c++)
            begin
                rgb_reg[c] <= quo[c];
            end
        end
    end

    mld_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({sq, 16'h0000}),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // One divider lane per axis
    for (genvar g = 0; g < 3; g++)
    begin : g_div
        mld_axis_div u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (num[g]),
            .den   (den),
            .done  (div_done[g]),
            .quo   (quo[g])
        );
    end

    assign out_red    = rgb_reg[0];
    assign out_green  = rgb_reg[1];
    assign out_blue   = rgb_reg[2];
    assign out_alpha  = alpha_reg;
    assign level_last = last_reg;

endmodule
`default_nettype wire

>>> design/mip_level_downsample_2x2.sv
// Top level: pixel position tracking, pairing and line store control of the mip downsampler.
`timescale 1ns / 1ps
`default_nettype none
// Accepts one RGBA pixel per transaction in raster order and delivers one pixel of the next
// mip level per 2x2 source block; level_last marks the final pixel of the level. A pixel that
// completes no block is accepted whenever the front end is idle. A pixel that completes a
// block is latched and then holds off the input while its block sum is formed from the line
// store read, and longer only if the result stage is still busy. In colour mode the result
// stage latches the block and then fills the output register. In normal mode a result is
// latched, its squared length is formed, the iterative square root runs its 19 digit steps,
// the three parallel 8-step dividers are set up and run, and the output register is filled;
// the square root loop is the longest part. While a result waits at the output, pixels that
// complete no block are still accepted and one more block is taken in before the input
// stalls. The line store needs no clearing after reset. A write to the width, height or mode
// register restarts the frame.
module mip_level_downsample_2x2 #(
    parameter int MAX_WIDTH = mld_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mld_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [mld_pkg::PIX_W-1:0]      in_red,
    input  wire logic [mld_pkg::PIX_W-1:0]      in_green,
    input  wire logic [mld_pkg::PIX_W-1:0]      in_blue,
    input  wire logic [mld_pkg::PIX_W-1:0]      in_alpha,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [mld_pkg::PIX_W-1:0]      out_red,
    output logic      [mld_pkg::PIX_W-1:0]      out_green,
    output logic      [mld_pkg::PIX_W-1:0]      out_blue,
    output logic      [mld_pkg::PIX_W-1:0]      out_alpha,
    output logic                                level_last
);
    import mld_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W     = ($clog2(LINE_DEPTH) < 1) ? 1 : $clog2(LINE_DEPTH);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int LINE_W     = 4 * PAIR_W;

    // Configuration
    logic [WIDTH_W-1:0]  src_width_reg;
    logic [HEIGHT_W-1:0] src_height_reg;
    logic                normal_mode_reg;
    logic                cfg_accept;

    // Frame position and held left pixel
    logic [COL_W-1:0]    col_reg;
    logic [HEIGHT_W-1:0] row_reg;
    logic [3:0][PIX_W-1:0] held_reg;

    // Pending block
    front_state_t          state_reg, state_next;
    job_kind_t             kind_reg;
    logic [3:0][SUM_W-1:0] base_reg;
    logic                  use_mem_reg;
    logic                  last_reg;

    logic                  in_accept;
    logic                  job_valid;
    logic                  job_ready;
    job_t                  job;

    logic [CMP_W-1:0]      w_raw, w_eff, h_eff, ow, oh;
    logic [CMP_W-1:0]      col_ext, col_inc, row_ext, row_inc, p_full, orow;
    logic [ADDR_W-1:0]     p;
    logic [3:0][PIX_W-1:0] px;
    logic [3:0][PAIR_W-1:0] pair;
    logic                  single, w_one, h_one, have_pair, row_in;
    logic                  line_wr, line_rd, emit, last;
    logic [3:0][PAIR_W-1:0] line_rd_data;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign in_accept  = in_valid && in_ready;
    assign px         = {in_alpha, in_blue, in_green, in_red};

    // Effective frame geometry
    always_comb
    begin
        w_raw = CMP_W'(src_width_reg);
        if (w_raw == '0)
        begin
            w_eff = CMP_W'(1);
        end
        else if (w_raw > CMP_W'(MAX_WIDTH))
        begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_raw;
        end
        h_eff = (src_height_reg == '0) ? CMP_W'(1) : CMP_W'(src_height_reg);
        ow    = ((w_eff >> 1) == '0) ? CMP_W'(1) : (w_eff >> 1);
        oh    = ((h_eff >> 1) == '0) ? CMP_W'(1) : (h_eff >> 1);
    end

    // Pairing and line store decisions for the offered pixel
    always_comb
    begin
        col_ext   = CMP_W'(col_reg);
        row_ext   = CMP_W'(row_reg);
        col_inc   = col_ext + 1'b1;
        row_inc   = row_ext + 1'b1;
        p_full    = col_ext >> 1;
        p         = p_full[ADDR_W-1:0];
        orow      = row_ext >> 1;
        w_one     = (w_eff == CMP_W'(1));
        h_one     = (h_eff == CMP_W'(1));
        single    = w_one && h_one;
        have_pair = !single && (w_one || col_reg[0]);
        for (int c = 0; c < 4; c++)
        begin
            pair[c] = w_one ? {px[c], 1'b0} : (PAIR_W'(held_reg[c]) + PAIR_W'(px[c]));
        end
        row_in  = (row_ext < (oh << 1));
        line_wr = have_pair && !h_one && row_in && !row_reg[0];
        line_rd = have_pair && !h_one && row_in && row_reg[0];
        emit    = single || (have_pair && (h_one || line_rd));
        last    = single || ((orow == oh - 1'b1) && (p_full == ow - 1'b1));
    end

    // Configuration registers and frame counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg   <= WIDTH_W'(1);
            src_height_reg  <= HEIGHT_W'(1);
            normal_mode_reg <= 1'b0;
            col_reg         <= '0;
            row_reg         <= '0;
            held_reg        <= '0;
        end
        else if (cfg_accept)
        begin
            unique case (cfg_index)
                CFG_WIDTH:
                begin
                    src_width_reg <= cfg_data[WIDTH_W-1:0];
                    col_reg       <= '0;
                    row_reg       <= '0;
                end
                CFG_HEIGHT:
                begin
                    src_height_reg <= cfg_data[HEIGHT_W-1:0];
                    col_reg        <= '0;
                    row_reg        <= '0;
                end
                CFG_MODE:
                begin
                    normal_mode_reg <= cfg_data[0];
                    col_reg         <= '0;
                    row_reg         <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (in_accept)
        begin
            if (!single && !w_one && !col_reg[0])
            begin
                held_reg <= px;
            end
            if (col_inc >= w_eff)
            begin
                col_reg <= '0;
                row_reg <= (row_inc >= h_eff) ? '0 : row_inc[HEIGHT_W-1:0];
            end
            else
            begin
                col_reg <= col_inc[COL_W-1:0];
            end
        end
    end

    // Block latch for the result stage
    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            use_mem_reg <= line_rd;
            last_reg    <= last;
            if (single)
            begin
                kind_reg <= JOB_RAW;
            end
            else
            begin
                kind_reg <= normal_mode_reg ? JOB_NORM : JOB_AVG;
            end
            for (int c = 0; c < 4; c++)
            begin
                if (single)
                begin
                    base_reg[c] <= SUM_W'(px[c]);
                end
                else if (h_one)
                begin
                    base_reg[c] <= {pair[c], 1'b0};
                end
                else
                begin
                    base_reg[c] <= SUM_W'(pair[c]);
                end
            end
        end
    end

    // Front state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        job_valid  = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && emit)
                begin
                    state_next = F_SEND;
                end
            end
            F_SEND:
            begin
                job_valid = 1'b1;
                if (job_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Block sum: stored even-row pair plus current pair, or the latched base alone
    always_comb
    begin
        job.kind = kind_reg;
        job.last = last_reg;
        for (int c = 0; c < 4; c++)
        begin
            job.sum[c] = use_mem_reg ? (SUM_W'(line_rd_data[c]) + base_reg[c]) : base_reg[c];
        end
    end

    mld_line_mem #(
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (LINE_W)
    ) u_line_mem (
        .clk         (clk),
        .wr_en       (in_accept && line_wr),
        .wr_addr     (p),
        .wr_data     (pair),
        .rd_en       (in_accept && line_rd),
        .rd_addr     (p),
        .rd_data_reg (line_rd_data)
    );

    mld_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .level_last (level_last)
    );

    // Column never reaches the effective width
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_ext < w_eff)
        else $error("column count out of range");

    // Row never reaches the effective height
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_ext < h_eff)
        else $error("row count out of range");

    // A line store read is always followed by handing the block on
    a_rd_send: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && line_rd) |=> (state_reg == F_SEND) && use_mem_reg)
        else $error("line store read without block hand-off");

endmodule
`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the 2x2 mip level downsampler.
`timescale 1ns / 1ps
module tb;
    import mld_pkg::*;

    localparam int LINE_ENTRIES = 4096;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 60;   // covers the normal-mode result pipeline

    // Register index beyond the register list
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] a;
        logic             last;
    } mip_pixel_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [PIX_W-1:0] in_red, in_green, in_blue, in_alpha;
    logic out_valid;
    logic out_ready;
    logic [PIX_W-1:0] out_red, out_green, out_blue, out_alpha;
    logic level_last;

    // Shadow of the block state
    logic [WIDTH_W-1:0]  shadow_width;
    logic [HEIGHT_W-1:0] shadow_height;
    logic                shadow_normal;
    logic [PAIR_W-1:0]   pair_line [0:LINE_ENTRIES-1][0:3];
    logic [PIX_W-1:0]    left_px [0:3];
    int unsigned         col_pos;
    int unsigned         row_pos;

    mip_pixel_t expected_pixels[$];

    int  error_count;
    int  pixels_sent;
    int  pixels_checked;
    int  normal_checked;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  recv_hold;

    mip_level_downsample_2x2 dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .in_alpha   (in_alpha),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .level_last (level_last)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d pixels pending", cycle_count,
                         expected_pixels.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR @%0t: %s", $realtime, what);
    endtask

    // Integer square root, bit-pair method
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Re-encode one normal axis: floor((255*(256v+L)+L)/(2L)), clamped
    function automatic logic [PIX_W-1:0] encode_normal_axis(input longint v, input longint len);
        longint num;
        longint q;
        num = 255 * (256 * v + len) + len;
        if (num <= 0)
            return '0;
        q = num / (2 * len);
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // Turn four-pixel channel sums into an expected output pixel
    task automatic expect_block(input int unsigned sum [0:3], input logic last);
        mip_pixel_t px;
        longint vec [0:2];
        longint unsigned sq;
        longint len;
        logic [PIX_W-1:0] chan [0:2];
        sq = 0;
        if (shadow_normal)
        begin
            for (int c = 0; c < 3; c++)
            begin
                vec[c] = 2 * longint'(sum[c]) - 1020;
                sq += longint'(vec[c] * vec[c]);
            end
            if (sq == 0)
            begin
                chan[0] = NORM_ZERO_XY;
                chan[1] = NORM_ZERO_XY;
                chan[2] = NORM_ZERO_Z;
            end
            else
            begin
                len = longint'(int_sqrt(sq << 16));
                for (int c = 0; c < 3; c++)
                    chan[c] = encode_normal_axis(vec[c], len);
            end
        end
        else
            for (int c = 0; c < 3; c++)
                chan[c] = 8'((sum[c] + 2) / 4);
        px.r    = chan[0];
        px.g    = chan[1];
        px.b    = chan[2];
        px.a    = 8'((sum[3] + 2) / 4);
        px.last = last;
        expected_pixels.insert(expected_pixels.size(), px);
    endtask

    // Advance the shadow by one accepted source pixel
    task automatic downsample_step(input logic [PIX_W-1:0] src [0:3]);
        int unsigned w, h, ow, oh, p, orow;
        int unsigned pair [0:3];
        int unsigned sum [0:3];
        bit have_pair;
        bit emit;
        mip_pixel_t px;
        w = (shadow_width == 0) ? 1 : shadow_width;
        h = (shadow_height == 0) ? 1 : shadow_height;
        if (w > MAX_WIDTH_DEF)
            w = MAX_WIDTH_DEF;
        have_pair = 0;
        emit = 0;
        p = 0;
        orow = 0;
        if (w == 1 && h == 1)
        begin
            px.r = src[0];
            px.g = src[1];
            px.b = src[2];
            px.a = src[3];
            px.last = 1'b1;
            expected_pixels.insert(expected_pixels.size(), px);
        end
        else
        begin
            ow = (w / 2 == 0) ? 1 : w / 2;
            oh = (h / 2 == 0) ? 1 : h / 2;
            if (w == 1)
            begin
                for (int c = 0; c < 4; c++)
                    pair[c] = 2 * src[c];
                have_pair = 1;
            end
            else if (col_pos[0])
            begin
                for (int c = 0; c < 4; c++)
                    pair[c] = left_px[c] + src[c];
                p = col_pos >> 1;
                have_pair = 1;
            end
            else
                for (int c = 0; c < 4; c++)
                    left_px[c] = src[c];
            if (have_pair && p < LINE_ENTRIES)
            begin
                if (h == 1)
                begin
                    for (int c = 0; c < 4; c++)
                        sum[c] = 2 * pair[c];
                    emit = 1;
                end
                else if (row_pos < 2 * oh)
                begin
                    if (!row_pos[0])
                        for (int c = 0; c < 4; c++)
                            pair_line[p][c] = pair[c][PAIR_W-1:0];
                    else
                    begin
                        for (int c = 0; c < 4; c++)
                            sum[c] = pair_line[p][c] + pair[c];
                        orow = row_pos >> 1;
                        emit = 1;
                    end
                end
                if (emit)
                    expect_block(sum, (orow == oh - 1) && (p == ow - 1));
            end
        end
        col_pos++;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h)
                row_pos = 0;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        mip_pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch($sformatf("unexpected pixel %0d,%0d,%0d,%0d", out_red,
                                          out_green, out_blue, out_alpha));
            else
            begin
                want = expected_pixels.pop_front();
                if (out_red !== want.r)
                    report_mismatch($sformatf("red %0d, want %0d", out_red, want.r));
                if (out_green !== want.g)
                    report_mismatch($sformatf("green %0d, want %0d", out_green, want.g));
                if (out_blue !== want.b)
                    report_mismatch($sformatf("blue %0d, want %0d", out_blue, want.b));
                if (out_alpha !== want.a)
                    report_mismatch($sformatf("alpha %0d, want %0d", out_alpha, want.a));
                if (level_last !== want.last)
                    report_mismatch($sformatf("level_last %0b, want %0b", level_last,
                                              want.last));
            end
            pixels_checked++;
            if (shadow_normal)
                normal_checked++;
        end
    end

    // Receiver: random stalls plus an optional long hold-off
    always @(posedge clk)
    begin
        if (recv_hold > 0)
        begin
            out_ready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_pixel(input logic [PIX_W-1:0] r, g, b, a);
        logic [PIX_W-1:0] src [0:3];
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_red   <= r;
        in_green <= g;
        in_blue  <= b;
        in_alpha <= a;
        do @(posedge clk); while (!in_ready);
        src[0] = r;
        src[1] = g;
        src[2] = b;
        src[3] = a;
        downsample_step(src);
        pixels_sent++;
    endtask

    // Drop valid, drain all results, then let the pipeline go quiet
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_WIDTH:  shadow_width  = val[WIDTH_W-1:0];
            CFG_HEIGHT: shadow_height = val[HEIGHT_W-1:0];
            CFG_MODE:   shadow_normal = val[0];
            default:    return;
        endcase
        col_pos = 0;
        row_pos = 0;
    endtask

    task automatic set_frame(input int w, input int h, input bit normal);
        write_reg(CFG_WIDTH, w[CFG_DATA_W-1:0]);
        write_reg(CFG_HEIGHT, h[CFG_DATA_W-1:0]);
        write_reg(CFG_MODE, {15'd0, normal});
    endtask

    // Random pixel; in normal mode often near the flat-normal encoding
    task automatic send_random_pixel();
        logic [PIX_W-1:0] r, g, b;
        if (shadow_normal && $urandom_range(3) == 0)
        begin
            r = 8'($urandom_range(127, 128));
            g = 8'($urandom_range(127, 128));
            b = 8'($urandom_range(127, 128));
        end
        else
        begin
            r = 8'($urandom);
            g = 8'($urandom);
            b = 8'($urandom);
        end
        send_pixel(r, g, b, 8'($urandom));
    endtask

    // Directed: 1x1 passthrough in both modes, value extremes
    task automatic test_single_pixel();
        set_frame(1, 1, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        write_reg(CFG_MODE, 16'd1);
        send_pixel(8'd255, 8'd0, 8'd170, 8'd85);
    endtask

    // Directed: 2x2 blocks with extremes, zero normal, rounding
    task automatic test_block_extremes();
        set_frame(2, 2, 1'b0);
        for (int i = 0; i < 4; i++)
            send_pixel(8'd255, 8'd0, 8'd1, 8'(i == 0 ? 2 : 0));
        write_reg(CFG_MODE, 16'd1);
        // sums of 510 on every axis give the zero vector
        send_pixel(8'd127, 8'd128, 8'd127, 8'd255);
        send_pixel(8'd128, 8'd127, 8'd128, 8'd0);
        send_pixel(8'd127, 8'd128, 8'd127, 8'd255);
        send_pixel(8'd128, 8'd127, 8'd128, 8'd255);
        for (int i = 0; i < 4; i++)
            send_pixel(8'd0, 8'd255, 8'd0, 8'd128);
    endtask

    // Directed: single column, single row, odd and zero sizes, oversize, bad index
    task automatic test_shapes();
        set_frame(1, 4, 1'b0);
        for (int i = 0; i < 4; i++)
            send_random_pixel();
        set_frame(4, 1, 1'b1);
        for (int i = 0; i < 4; i++)
            send_random_pixel();
        set_frame(3, 3, 1'b0);
        for (int i = 0; i < 9; i++)
            send_random_pixel();
        set_frame(0, 0, 1'b0);
        send_random_pixel();
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_random_pixel();
        set_frame(16383, 2, 1'b0);
        for (int i = 0; i < 20; i++)
            send_random_pixel();
        write_reg(CFG_HEIGHT, 16'd65535);
        for (int i = 0; i < 6; i++)
            send_random_pixel();
    endtask

    // Receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        set_frame(8, 8, 1'b1);
        recv_hold = 400;
        for (int i = 0; i < 64; i++)
            send_random_pixel();
    endtask

    // Random frames, mostly complete, some cut short
    task automatic test_random_frames(input int items);
        int sent;
        int w, h, n;
        sent = 0;
        while (sent < items)
        begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            set_frame(w, h, 1'($urandom));
            n = w * h * $urandom_range(1, 2);
            if ($urandom_range(4) == 0)
                n = $urandom_range(1, w * h);
            if (n > items - sent)
                n = items - sent;
            for (int i = 0; i < n; i++)
                send_random_pixel();
            sent += n;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_red = '0;
        in_green = '0;
        in_blue = '0;
        in_alpha = '0;
        out_ready = 1'b0;
        error_count = 0;
        pixels_sent = 0;
        pixels_checked = 0;
        normal_checked = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 0;
        shadow_width = 1;
        shadow_height = 1;
        shadow_normal = 1'b0;
        col_pos = 0;
        row_pos = 0;
        for (int i = 0; i < 2; i++)
            left_px[i] = '0;
        for (int i = 2; i < 4; i++)
            left_px[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 52;
        test_single_pixel();
        test_block_extremes();
        test_shapes();
        test_random_frames(475);
        test_backpressure();

        send_idle_pct = 52;
        recv_idle_pct = 20;
        test_random_frames(475);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(475);

        drain_results();
        $display("Covered %0d source pixels and %0d mip pixels (%0d in normal mode),",
                 pixels_sent, pixels_checked, normal_checked);
        $display("1x1, single row/column, odd, zero and oversize frames, long output stall.");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
